FILE: hw/rtl/bfa_pkg.sv
// Shared constants, status codes and field widths for the best-fit allocator.
// No dependencies.
package bfa_pkg;
  localparam int FREE_ENTRIES_DEF = 64;
  localparam int ADDR_BITS        = 32;
  localparam int LEN_BITS         = ADDR_BITS + 1;
  localparam int COUNT_BITS       = 24;
  localparam int SIZE_BITS        = 16;
  localparam int NEED_BITS        = COUNT_BITS + SIZE_BITS;
  localparam int USED_BITS        = 7;
  localparam logic [ADDR_BITS-1:0] POOL_RESET = ADDR_BITS'(1048576);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;
endpackage

FILE: hw/rtl/bfa_if.sv
// Request and response channel interfaces of the allocator.
// Depends on bfa_pkg.
interface bfa_req_if import bfa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COUNT_BITS-1:0] element_count;
  logic [SIZE_BITS-1:0]  element_size;
  logic [ADDR_BITS-1:0]  release_offset;
  modport source (output valid, action, element_count, element_size, release_offset,
                  input ready);
  modport sink   (input valid, action, element_count, element_size, release_offset,
                  output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ADDR_BITS-1:0] offset;
  logic [USED_BITS-1:0] entries_used;
  modport source (output valid, status, offset, entries_used, input ready);
  modport sink   (input valid, status, offset, entries_used, output ready);
endinterface

FILE: hw/rtl/bfa_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/bfa_rem.sv
// Restoring remainder unit, one dividend bit per cycle.
// Depends on bfa_pkg.
module bfa_rem import bfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [ADDR_BITS-1:0] dividend,
  input  logic [SIZE_BITS-1:0] divisor,
  output logic                 done,
  output logic [SIZE_BITS-1:0] rem
);
  localparam int STEP_W = $clog2(ADDR_BITS);

  logic                 busy;
  logic [STEP_W-1:0]    step;
  logic [ADDR_BITS-1:0] quo;
  logic [SIZE_BITS-1:0] dsr;
  logic [SIZE_BITS:0]   trial;

  assign trial = {rem, quo[ADDR_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        quo  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        quo <= {quo[ADDR_BITS-2:0], 1'b0};
        if (trial >= {1'b0, dsr}) begin
          rem <= SIZE_BITS'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[SIZE_BITS-1:0];
        end
        step <= step + 1'b1;
        if (step == STEP_W'(ADDR_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hw/rtl/best_fit_aligned_free_list_allocator_core.sv
// Top level: best-fit aligned free-list allocator, list held in one RAM.
// Depends on bfa_pkg, bfa_if, bfa_ram, bfa_rem.
//
//  channel  | dir | payload
//  req      | in  | action, element_count, element_size, release_offset
//  rsp      | out | status, offset, entries_used
//  cfg      | in  | cfg_we, cfg_wdata (pool_bytes)
//
// Release word: prep, release write and done states; rejected word: prep and done.
// Allocate: each list entry scanned takes a RAM read, the remainder unit and a compare,
// each entry shifted a read and a write, plus setup, scan end and the gap and tail pushes.
// The init state after rst writes entry 0. A stalled rsp holds the finished word
// and the next req word is taken once it is in the output register.
module best_fit_aligned_free_list_allocator_core import bfa_pkg::*; #(
  parameter int FREE_ENTRIES = FREE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [ADDR_BITS-1:0] cfg_wdata,
  bfa_req_if.sink              req,
  bfa_rsp_if.source            rsp
);
  localparam int AW = $clog2(FREE_ENTRIES);
  localparam int CW = $clog2(FREE_ENTRIES + 1);
  localparam int EW = ADDR_BITS + 2;
  localparam int MW = ADDR_BITS + LEN_BITS;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_PREP, S_REL, S_SCAN_RD, S_SCAN_LD, S_DIV, S_EVAL,
    S_FIN, S_SH_RD, S_SH_WR, S_PUSH_GAP, S_PUSH_TAIL, S_DONE
  } state_t;

  state_t state;
  logic [CW-1:0]         cnt, idx, best;
  logic                  act;
  logic [COUNT_BITS-1:0] r_count;
  logic [SIZE_BITS-1:0]  r_size;
  logic [ADDR_BITS-1:0]  r_roff;
  logic [NEED_BITS-1:0]  need;
  logic [ADDR_BITS-1:0]  b;
  logic [LEN_BITS-1:0]   len;
  logic                  found;
  logic [ADDR_BITS-1:0]  best_b;
  logic [EW-1:0]         best_al, best_e, best_use;
  logic [1:0]            res_status;
  logic [ADDR_BITS-1:0]  res_offset;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [MW-1:0]         wdata, rdata;
  logic                  div_done;
  logic [SIZE_BITS-1:0]  rem;

  logic [EW-1:0]         al, e, usable, room;
  logic                  fits;
  logic [NEED_BITS:0]    alloc_end;
  logic                  gap, tail;
  logic [CW:0]           after, idx_n;
  logic [LEN_BITS-1:0]   rel_len;

  bfa_ram #(.WIDTH(MW), .DEPTH(FREE_ENTRIES)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  bfa_rem u_rem (
    .clk, .rst, .start(state == S_SCAN_LD), .dividend(rdata[MW-1:LEN_BITS]),
    .divisor(r_size), .done(div_done), .rem
  );

  always_comb begin
    al = {2'b0, b} + ((rem == '0) ? EW'(0) : EW'(r_size - rem));
    e  = EW'(b) + EW'(len);
    usable = e - al;
    fits = (al < e) && ((NEED_BITS+1)'(usable) >= {1'b0, need}) &&
           (!found || usable < best_use);
    alloc_end = (NEED_BITS+1)'(best_al) + {1'b0, need};
    gap  = best_al > EW'(best_b);
    tail = alloc_end < (NEED_BITS+1)'(best_e);
    after = {1'b0, cnt} - 1'b1 + (CW+1)'(gap) + (CW+1)'(tail);
    idx_n = {1'b0, idx} + 1'b1;
    room = (EW'(1) << ADDR_BITS) - EW'(r_roff);
    rel_len = ((NEED_BITS+1)'(room) < {1'b0, need}) ? LEN_BITS'(room) : LEN_BITS'(need);
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt[AW-1:0];
    wdata = '0;
    raddr = idx[AW-1:0];
    if (state == S_SH_RD) begin
      raddr = idx_n[AW-1:0];
    end
    if (cfg_we) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {ADDR_BITS'(0), 1'b0, cfg_wdata};
    end else begin
      case (state)
        S_INIT: begin
          we    = 1'b1;
          waddr = '0;
          wdata = {ADDR_BITS'(0), 1'b0, POOL_RESET};
        end
        S_REL: begin
          we    = cnt < CW'(FREE_ENTRIES);
          wdata = {r_roff, rel_len};
        end
        S_SH_WR: begin
          we    = 1'b1;
          waddr = idx[AW-1:0];
          wdata = rdata;
        end
        S_PUSH_GAP: begin
          we    = gap;
          wdata = {best_b, LEN_BITS'(best_al - EW'(best_b))};
        end
        S_PUSH_TAIL: begin
          we    = tail;
          wdata = {alloc_end[ADDR_BITS-1:0], LEN_BITS'((NEED_BITS+1)'(best_e) - alloc_end)};
        end
        default: ;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= CW'(1);
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (req.valid) begin
            act     <= req.action;
            r_count <= req.element_count;
            r_size  <= req.element_size;
            r_roff  <= req.release_offset;
            state   <= S_PREP;
          end
        end
        S_PREP: begin
          need       <= NEED_BITS'(r_count) * NEED_BITS'(r_size);
          idx        <= '0;
          found      <= 1'b0;
          res_offset <= '0;
          if (r_count == '0 || r_size == '0) begin
            res_status <= ST_NOFIT;
            state      <= S_DONE;
          end else if (act == ACT_RELEASE) begin
            state <= S_REL;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_REL: begin
          if (cnt >= CW'(FREE_ENTRIES)) begin
            res_status <= ST_FULL;
          end else begin
            cnt        <= cnt + 1'b1;
            res_status <= ST_OK;
          end
          state <= S_DONE;
        end
        S_SCAN_RD: state <= (idx < cnt) ? S_SCAN_LD : S_FIN;
        S_SCAN_LD: begin
          b     <= rdata[MW-1:LEN_BITS];
          len   <= rdata[LEN_BITS-1:0];
          state <= S_DIV;
        end
        S_DIV: if (div_done) state <= S_EVAL;
        S_EVAL: begin
          if (fits) begin
            found    <= 1'b1;
            best     <= idx;
            best_b   <= b;
            best_al  <= al;
            best_e   <= e;
            best_use <= usable;
          end
          idx   <= idx_n[CW-1:0];
          state <= S_SCAN_RD;
        end
        S_FIN: begin
          idx <= best;
          if (!found) begin
            res_status <= ST_NOFIT;
            state      <= S_DONE;
          end else if (after > (CW+1)'(FREE_ENTRIES)) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            state <= S_SH_RD;
          end
        end
        S_SH_RD: begin
          if (idx_n < {1'b0, cnt}) begin
            state <= S_SH_WR;
          end else begin
            cnt   <= cnt - 1'b1;
            state <= S_PUSH_GAP;
          end
        end
        S_SH_WR: begin
          idx   <= idx_n[CW-1:0];
          state <= S_SH_RD;
        end
        S_PUSH_GAP: begin
          if (gap) cnt <= cnt + 1'b1;
          state <= S_PUSH_TAIL;
        end
        S_PUSH_TAIL: begin
          if (tail) cnt <= cnt + 1'b1;
          res_status <= ST_OK;
          res_offset <= best_al[ADDR_BITS-1:0];
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.offset       <= res_offset;
            rsp.entries_used <= USED_BITS'(cnt);
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        cnt <= CW'(1);
      end
    end
  end
endmodule

FILE: tb/best_fit_aligned_free_list_allocator_core_test.sv
// Testbench for the best-fit aligned free-list allocator core.
// Drives request words from a directed table then at random, predicts each response (typed in for some rows).
// Depends on bfa_pkg, bfa_if and the core RTL.
module best_fit_aligned_free_list_allocator_core_test import bfa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = FREE_ENTRIES_DEF;
  localparam longint SPAN = 64'd1 << ADDR_BITS;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DIR_ROWS = 18;
  localparam int EXP_DEPTH = 64;

  typedef struct packed {
    logic                  action;
    logic [COUNT_BITS-1:0] element_count;
    logic [SIZE_BITS-1:0]  element_size;
    logic [ADDR_BITS-1:0]  release_offset;
  } req_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] offset;
    logic [USED_BITS-1:0] entries_used;
  } rsp_word_t;

  typedef struct {
    req_word_t w;
    logic      known;
    rsp_word_t r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ADDR_BITS-1:0] cfg_wdata = '0;

  bfa_req_if req ();
  bfa_rsp_if rsp ();

  best_fit_aligned_free_list_allocator_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .req(req), .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  longint unsigned pool_len;
  longint unsigned list_off[NUM_ENTRIES];
  longint unsigned list_len[NUM_ENTRIES];
  int              list_used;
  rsp_word_t       exp_ring[EXP_DEPTH];
  int              exp_wr = 0;
  int              exp_rd = 0;
  int              mismatches = 0;
  int              cycles = 0;
  int              send_idle = 37;
  int              recv_idle = 71;

  function automatic void reload_list(logic [ADDR_BITS-1:0] bytes);
    pool_len = bytes;
    list_off[0] = 0;
    list_len[0] = pool_len;
    list_used = 1;
  endfunction

  function automatic longint unsigned round_up(longint unsigned v, longint unsigned a);
    return (v + a - 1) / a * a;
  endfunction

  function automatic void append_range(longint unsigned o, longint unsigned l);
    if (list_used < NUM_ENTRIES) begin
      list_off[list_used] = o & (SPAN - 1);
      list_len[list_used] = l;
      list_used++;
    end
  endfunction

  function automatic rsp_word_t predict_rsp(req_word_t w);
    rsp_word_t r;
    longint unsigned cnt, sz, need, b, e, al, usable, best_use, alloc_end, room, o, l;
    int best, after;
    bit found;
    status_t st;
    longint unsigned granted;
    cnt = w.element_count;
    sz = w.element_size;
    granted = 0;
    found = 0;
    best = 0;
    best_use = 0;
    if (cnt == 0 || sz == 0) begin
      st = ST_NOFIT;
    end else if (w.action == ACT_ALLOC) begin
      need = cnt * sz;
      for (int i = 0; i < list_used; i++) begin
        b = list_off[i];
        e = b + list_len[i];
        al = round_up(b, sz);
        if (al < e) begin
          usable = e - al;
          if (usable >= need && (!found || usable < best_use)) begin
            best_use = usable;
            best = i;
            found = 1;
          end
        end
      end
      if (!found) begin
        st = ST_NOFIT;
      end else begin
        b = list_off[best];
        e = b + list_len[best];
        al = round_up(b, sz);
        alloc_end = al + need;
        after = list_used - 1 + (al > b) + (alloc_end < e);
        if (after > NUM_ENTRIES) begin
          st = ST_FULL;
        end else begin
          for (int i = best; i + 1 < list_used; i++) begin
            list_off[i] = list_off[i+1];
            list_len[i] = list_len[i+1];
          end
          list_used--;
          if (al > b) append_range(b, al - b);
          if (alloc_end < e) append_range(alloc_end, e - alloc_end);
          granted = al;
          st = ST_OK;
        end
      end
    end else begin
      o = w.release_offset;
      l = cnt * sz;
      room = SPAN - o;
      if (l > room) l = room;
      if (list_used >= NUM_ENTRIES) begin
        st = ST_FULL;
      end else begin
        append_range(o, l);
        st = ST_OK;
      end
    end
    r.status = st;
    r.offset = (st == ST_OK) ? granted[ADDR_BITS-1:0] : '0;
    r.entries_used = USED_BITS'(list_used);
    return r;
  endfunction

  // response side
  always @(posedge clk) begin
    rsp_word_t got, want;
    cycles <= cycles + 1;
    if (!rst) begin
      rsp.ready <= ($urandom_range(99) >= recv_idle);
      if (rsp.valid && rsp.ready) begin
        got.status = rsp.status;
        got.offset = rsp.offset;
        got.entries_used = rsp.entries_used;
        if (exp_wr == exp_rd) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %p", got);
        end else begin
          want = exp_ring[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_word(req_word_t w);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.action <= w.action;
    req.element_count <= w.element_count;
    req.element_size <= w.element_size;
    req.release_offset <= w.release_offset;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    exp_ring[exp_wr % EXP_DEPTH] = predict_rsp(w);
    exp_wr++;
  endtask

  task automatic drain;
    req.valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_pool(logic [ADDR_BITS-1:0] bytes);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    reload_list(bytes);
    @(posedge clk);
  endtask

  function automatic req_word_t rand_word(int pool_sel);
    req_word_t w;
    int k;
    w.action = ($urandom_range(99) < 40) ? ACT_RELEASE : ACT_ALLOC;
    k = $urandom_range(99);
    if (k < 4) w.element_count = '0;
    else if (k < 10) w.element_count = COUNT_BITS'($urandom);
    else w.element_count = COUNT_BITS'($urandom_range(64, 1));
    k = $urandom_range(99);
    if (k < 3) w.element_size = '0;
    else if (k < 10) w.element_size = SIZE_BITS'($urandom);
    else w.element_size = SIZE_BITS'(1 << $urandom_range(8));
    if ($urandom_range(99) < 60)
      w.release_offset = $urandom_range(pool_sel ? 32'hFFFF_FFFF : 32'h0010_0000);
    else
      w.release_offset = $urandom;
    return w;
  endfunction

  dir_row_t dir_table[DIR_ROWS];

  initial begin
    req_word_t w;
    req.valid = 1'b0;
    req.action = ACT_ALLOC;
    req.element_count = '0;
    req.element_size = '0;
    req.release_offset = '0;
    rsp.ready = 1'b0;
    reload_list(POOL_RESET);

    // {word, typed-in, expected}
    dir_table[0]  = '{'{ACT_ALLOC, 24'd0, 16'd4, 32'd0}, 1, '{ST_NOFIT, 32'd0, 7'd1}};
    dir_table[1]  = '{'{ACT_ALLOC, 24'd4, 16'd0, 32'd0}, 1, '{ST_NOFIT, 32'd0, 7'd1}};
    dir_table[2]  = '{'{ACT_RELEASE, 24'd0, 16'd1, 32'd5}, 1, '{ST_NOFIT, 32'd0, 7'd1}};
    dir_table[3]  = '{'{ACT_ALLOC, 24'hFFFFFF, 16'hFFFF, 32'd0}, 1, '{ST_NOFIT, 32'd0, 7'd1}};
    dir_table[4]  = '{'{ACT_ALLOC, 24'd1, 16'd16, 32'hFFFFFFFF}, 1, '{ST_OK, 32'd0, 7'd1}};
    dir_table[5]  = '{'{ACT_ALLOC, 24'd3, 16'd1, 32'd0}, 0, '0};
    dir_table[6]  = '{'{ACT_ALLOC, 24'd1, 16'd64, 32'd0}, 0, '0};
    dir_table[7]  = '{'{ACT_RELEASE, 24'd1, 16'd16, 32'd0}, 0, '0};
    dir_table[8]  = '{'{ACT_RELEASE, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF}, 0, '0};
    dir_table[9]  = '{'{ACT_RELEASE, 24'd2, 16'd8, 32'hAAAA5555}, 0, '0};
    dir_table[10] = '{'{ACT_ALLOC, 24'd1, 16'd8, 32'd0}, 0, '0};
    dir_table[11] = '{'{ACT_ALLOC, 24'd2, 16'hFFFF, 32'd0}, 0, '0};
    dir_table[12] = '{'{ACT_ALLOC, 24'd1, 16'd1, 32'd0}, 0, '0};
    dir_table[13] = '{'{ACT_ALLOC, 24'd5, 16'd3, 32'd0}, 0, '0};
    dir_table[14] = '{'{ACT_RELEASE, 24'h555555, 16'h5555, 32'h12345678}, 0, '0};
    dir_table[15] = '{'{ACT_ALLOC, 24'hAAAAAA, 16'd1, 32'd0}, 0, '0};
    dir_table[16] = '{'{ACT_RELEASE, 24'd1, 16'd1, 32'h0}, 0, '0};
    dir_table[17] = '{'{ACT_ALLOC, 24'd1, 16'hAAAA, 32'd0}, 0, '0};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_table[i].w);
      if (dir_table[i].known) begin
        exp_ring[(exp_wr - 1) % EXP_DEPTH] = dir_table[i].r;
      end
    end

    // zero pool: nothing fits; then the widest pool
    write_pool(32'd0);
    send_word('{ACT_ALLOC, 24'd1, 16'd1, 32'd0});
    write_pool(32'hFFFFFFFF);
    send_word('{ACT_ALLOC, 24'd1, 16'd1, 32'd0});
    send_word('{ACT_ALLOC, 24'hFFFFFF, 16'hFFFF, 32'd0});

    // fill the list to its limit with releases
    write_pool(32'd4096);
    for (int i = 0; i < 64; i++)
      send_word('{ACT_RELEASE, 24'd1, 16'd3, 32'(8192 + 8 * i)});
    send_word('{ACT_ALLOC, 24'd1, 16'd2, 32'd0});
    send_word('{ACT_ALLOC, 24'd1, 16'd1, 32'd0});

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle = 71;
        recv_idle = 37;
      end else if (ph == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_pool(ph == 1 ? 32'hFFFFFFFF : (ph == 0 ? 32'd1 << 20 : 32'd1));
      for (int n = 0; n < 60; n++) begin
        send_word(rand_word(ph == 1));
        if (n == 30) drain();
      end
    end
    write_pool(32'h0000_5000);
    for (int n = 0; n < 20; n++) send_word(rand_word(0));

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_if.sv
hw/rtl/bfa_ram.sv
hw/rtl/bfa_rem.sv
hw/rtl/best_fit_aligned_free_list_allocator_core.sv
tb/best_fit_aligned_free_list_allocator_core_test.sv
